FILE: sv/rsi_pkg.sv
package rsi_pkg;

  localparam int DIVIDE_FRAC_BITS = 16;
  localparam int DW = 50;                         // |cross| width
  localparam logic [30:0] RAY_LENGTH_RESET = 31'd65536000;
  localparam logic [33:0] OFS_CAP = 34'h2_0000_0000;

  // per-item data that rides alongside the divider
  typedef struct packed {
    logic        hit;
    logic [31:0] ox;
    logic [31:0] oy;
    logic [15:0] dxm;
    logic [15:0] dym;
    logic        dxn;
    logic        dyn;
    logic [31:0] miss_x;
    logic [31:0] miss_y;
  } side_t;

  // origin plus or minus a magnitude, saturated to signed 32 bits
  function automatic logic [31:0] place(logic [31:0] org, logic [33:0] mm, logic neg);
    logic [35:0] o;
    logic [35:0] v;
    o = {{4{org[31]}}, org};
    v = neg ? (o - {2'b0, mm}) : (o + {2'b0, mm});
    if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
      place = v[31:0];
    end else if (v[35]) begin
      place = 32'h8000_0000;
    end else begin
      place = 32'h7FFF_FFFF;
    end
  endfunction

endpackage

FILE: sv/rsi_front.sv
module rsi_front #(
  parameter int DIVIDE_FRAC_BITS = rsi_pkg::DIVIDE_FRAC_BITS,
  parameter int K = DIVIDE_FRAC_BITS + 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [31:0]      origin_x,
  input  logic signed [31:0]      origin_y,
  input  logic signed [15:0]      dir_x,
  input  logic signed [15:0]      dir_y,
  input  logic signed [31:0]      seg_ax,
  input  logic signed [31:0]      seg_ay,
  input  logic signed [31:0]      seg_bx,
  input  logic signed [31:0]      seg_by,
  input  logic [30:0]             ray_length,
  output logic                    o_valid,
  output rsi_pkg::side_t          o_side,
  output logic [rsi_pkg::DW-1:0]  o_rem,
  output logic [K-1:0]            o_dvd,
  output logic [rsi_pkg::DW-1:0]  o_dvs,
  output logic                    o_ovf
);

  localparam int DW = rsi_pkg::DW;

  // stage 1: differences, miss products
  logic               v1;
  logic signed [32:0] sx1, sy1, qx1, qy1;
  logic signed [15:0] dx1, dy1;
  logic [31:0]        ox1, oy1;
  logic [46:0]        mpx1, mpy1;
  logic [15:0]        dxm_in, dym_in;

  assign dxm_in = dir_x[15] ? 16'(-dir_x) : dir_x;
  assign dym_in = dir_y[15] ? 16'(-dir_y) : dir_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      sx1  <= 33'(seg_bx) - 33'(seg_ax);
      sy1  <= 33'(seg_by) - 33'(seg_ay);
      qx1  <= 33'(seg_ax) - 33'(origin_x);
      qy1  <= 33'(seg_ay) - 33'(origin_y);
      dx1  <= dir_x;
      dy1  <= dir_y;
      ox1  <= origin_x;
      oy1  <= origin_y;
      mpx1 <= {16'b0, ray_length} * {31'b0, dxm_in};
      mpy1 <= {16'b0, ray_length} * {31'b0, dym_in};
    end
  end

  // stage 2: products, miss end points
  logic               v2;
  logic signed [48:0] p_dxsy, p_dysx, p_qxdy, p_qydx;
  logic signed [65:0] p_qxsy, p_qysx;
  rsi_pkg::side_t     sd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      p_dxsy <= dx1 * sy1;
      p_dysx <= dy1 * sx1;
      p_qxdy <= qx1 * dy1;
      p_qydx <= qy1 * dx1;
      p_qxsy <= qx1 * sy1;
      p_qysx <= qy1 * sx1;
      sd2.hit    <= 1'b0;
      sd2.ox     <= ox1;
      sd2.oy     <= oy1;
      sd2.dxm    <= dx1[15] ? 16'(-dx1) : dx1;
      sd2.dym    <= dy1[15] ? 16'(-dy1) : dy1;
      sd2.dxn    <= dx1[15];
      sd2.dyn    <= dy1[15];
      sd2.miss_x <= rsi_pkg::place(ox1, {2'b0, mpx1[46:15]}, dx1[15]);
      sd2.miss_y <= rsi_pkg::place(oy1, {2'b0, mpy1[46:15]}, dy1[15]);
    end
  end

  // stage 3: cross products
  logic               v3;
  logic signed [49:0] cross3, unum3;
  logic signed [66:0] tnum3;
  rsi_pkg::side_t     sd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      cross3 <= 50'(p_dxsy) - 50'(p_dysx);
      unum3  <= 50'(p_qxdy) - 50'(p_qydx);
      tnum3  <= 67'(p_qxsy) - 67'(p_qysx);
      sd3    <= sd2;
    end
  end

  // stage 4: hit decision, magnitudes
  logic           v4;
  logic [66:0]    tmag4;
  logic [DW-1:0]  cmag4;
  rsi_pkg::side_t sd4;
  rsi_pkg::side_t sd3h;
  logic           hit3;

  always_comb begin
    hit3 = 1'b0;
    if (!cross3[49] && cross3 != '0) begin
      hit3 = !tnum3[66] && !unum3[49] && (unum3 <= cross3);
    end else if (cross3[49]) begin
      hit3 = (tnum3[66] || tnum3 == '0) && (unum3[49] || unum3 == '0) && (unum3 >= cross3);
    end
  end

  always_comb begin
    sd3h     = sd3;
    sd3h.hit = hit3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      tmag4 <= tnum3[66] ? 67'(-tnum3) : tnum3;
      cmag4 <= cross3[49] ? 50'(-cross3) : cross3;
      sd4   <= sd3h;
    end
  end

  // stage 5: divider setup; quotient saturates when |tnum| >= |cross| << 33
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= v4;
    end
    if (en) begin
      o_side <= sd4;
      o_rem  <= {16'b0, tmag4[66:33]};
      o_dvd  <= {tmag4[32:0], {(DIVIDE_FRAC_BITS-1){1'b0}}};
      o_dvs  <= cmag4;
      o_ovf  <= ({16'b0, tmag4[66:33]} >= cmag4);
    end
  end

endmodule

FILE: sv/rsi_div_step.sv
module rsi_div_step #(
  parameter int K = rsi_pkg::DIVIDE_FRAC_BITS + 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    i_valid,
  input  rsi_pkg::side_t          i_side,
  input  logic [rsi_pkg::DW-1:0]  i_rem,
  input  logic [K-1:0]            i_dvd,
  input  logic [K-1:0]            i_quo,
  input  logic [rsi_pkg::DW-1:0]  i_dvs,
  input  logic                    i_ovf,
  output logic                    o_valid,
  output rsi_pkg::side_t          o_side,
  output logic [rsi_pkg::DW-1:0]  o_rem,
  output logic [K-1:0]            o_dvd,
  output logic [K-1:0]            o_quo,
  output logic [rsi_pkg::DW-1:0]  o_dvs,
  output logic                    o_ovf
);

  localparam int DW = rsi_pkg::DW;

  logic [DW:0] r2;
  logic [DW:0] diff;
  logic        ge;

  // one restoring step
  assign r2   = {i_rem, i_dvd[K-1]};
  assign diff = r2 - {1'b0, i_dvs};
  assign ge   = (r2 >= {1'b0, i_dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= i_valid;
    end
    if (en) begin
      o_side <= i_side;
      o_rem  <= ge ? diff[DW-1:0] : r2[DW-1:0];
      o_dvd  <= {i_dvd[K-2:0], 1'b0};
      o_quo  <= {i_quo[K-2:0], ge};
      o_dvs  <= i_dvs;
      o_ovf  <= i_ovf;
    end
  end

endmodule

FILE: sv/rsi_back.sv
module rsi_back #(
  parameter int DIVIDE_FRAC_BITS = rsi_pkg::DIVIDE_FRAC_BITS,
  parameter int K = DIVIDE_FRAC_BITS + 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                i_valid,
  input  rsi_pkg::side_t      i_side,
  input  logic [K-1:0]        i_quo,
  input  logic                i_ovf,
  output logic                o_valid,
  output logic                o_hit,
  output logic signed [31:0]  o_end_x,
  output logic signed [31:0]  o_end_y
);

  localparam int PW = K + 17;
  localparam int OW = PW - (DIVIDE_FRAC_BITS - 1);

  logic [K:0]     t;
  logic           v1;
  logic [PW-1:0]  px1, py1;
  rsi_pkg::side_t sd1;

  // saturated t: any larger value already pushes the offset to or past the cap
  assign t = i_ovf ? {1'b1, {K{1'b0}}} : {1'b0, i_quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= i_valid;
    end
    if (en) begin
      px1 <= PW'(t) * PW'(i_side.dxm);
      py1 <= PW'(t) * PW'(i_side.dym);
      sd1 <= i_side;
    end
  end

  logic [OW-1:0] ofx, ofy;
  logic [33:0]   mx, my;

  assign ofx = px1[PW-1:DIVIDE_FRAC_BITS-1];
  assign ofy = py1[PW-1:DIVIDE_FRAC_BITS-1];
  assign mx  = (ofx > OW'(rsi_pkg::OFS_CAP)) ? rsi_pkg::OFS_CAP : ofx[33:0];
  assign my  = (ofy > OW'(rsi_pkg::OFS_CAP)) ? rsi_pkg::OFS_CAP : ofy[33:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= v1;
    end
    if (en) begin
      o_hit   <= sd1.hit;
      o_end_x <= sd1.hit ? rsi_pkg::place(sd1.ox, mx, sd1.dxn) : sd1.miss_x;
      o_end_y <= sd1.hit ? rsi_pkg::place(sd1.oy, my, sd1.dyn) : sd1.miss_y;
    end
  end

endmodule

FILE: sv/ray_segment_intersect_top.sv
// Ray against line segment intersection, 2-D fixed point. Each input transfer
// carries a ray (origin Q16.16, direction Q1.15) and a segment (endpoints
// Q16.16); each one yields exactly one output transfer with a hit flag and the
// ray end point: the intersection on a hit, else origin + dir * ray_length,
// saturated to Q16.16. A parallel ray, a zero direction or a point segment
// never hits; touching either segment end or the origin counts as a hit.
// Throughput is one transfer per clock while the output is not stalled. The
// pipeline has five setup stages, one restoring divider stage per quotient
// bit (DIVIDE_FRAC_BITS + 32 of them), and two output stages. The whole
// pipeline advances together; it holds only while the output register is
// full and stalled. ray_length is written through cfg_wr_en / cfg_wr_data
// and should only change while no transfer is in flight.
module ray_segment_intersect_top #(
  parameter int DIVIDE_FRAC_BITS = rsi_pkg::DIVIDE_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [30:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [31:0] seg_ax,
  input  logic signed [31:0] seg_ay,
  input  logic signed [31:0] seg_bx,
  input  logic signed [31:0] seg_by,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic signed [31:0] end_x,
  output logic signed [31:0] end_y
);

  localparam int K  = DIVIDE_FRAC_BITS + 32;   // quotient bits = divider stages
  localparam int DW = rsi_pkg::DW;

  logic [30:0] ray_length;
  logic        en;

  always_ff @(posedge clk) begin
    if (rst) begin
      ray_length <= rsi_pkg::RAY_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      ray_length <= cfg_wr_data;
    end
  end

  // global advance: only a full, stalled output register holds the pipe
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic           dv  [K+1];
  rsi_pkg::side_t dsd [K+1];
  logic [DW-1:0]  drem[K+1];
  logic [K-1:0]   ddvd[K+1];
  logic [K-1:0]   dquo[K+1];
  logic [DW-1:0]  ddvs[K+1];
  logic           dovf[K+1];

  rsi_front #(.DIVIDE_FRAC_BITS(DIVIDE_FRAC_BITS), .K(K)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .origin_x(origin_x), .origin_y(origin_y), .dir_x(dir_x), .dir_y(dir_y),
    .seg_ax(seg_ax), .seg_ay(seg_ay), .seg_bx(seg_bx), .seg_by(seg_by),
    .ray_length(ray_length),
    .o_valid(dv[0]), .o_side(dsd[0]), .o_rem(drem[0]), .o_dvd(ddvd[0]),
    .o_dvs(ddvs[0]), .o_ovf(dovf[0])
  );

  assign dquo[0] = '0;

  // one quotient bit per stage, MSB first
  for (genvar i = 0; i < K; i++) begin : g_div
    rsi_div_step #(.K(K)) u_step (
      .clk(clk), .rst(rst), .en(en),
      .i_valid(dv[i]), .i_side(dsd[i]), .i_rem(drem[i]), .i_dvd(ddvd[i]),
      .i_quo(dquo[i]), .i_dvs(ddvs[i]), .i_ovf(dovf[i]),
      .o_valid(dv[i+1]), .o_side(dsd[i+1]), .o_rem(drem[i+1]), .o_dvd(ddvd[i+1]),
      .o_quo(dquo[i+1]), .o_dvs(ddvs[i+1]), .o_ovf(dovf[i+1])
    );
  end

  rsi_back #(.DIVIDE_FRAC_BITS(DIVIDE_FRAC_BITS), .K(K)) u_back (
    .clk(clk), .rst(rst), .en(en),
    .i_valid(dv[K]), .i_side(dsd[K]), .i_quo(dquo[K]), .i_ovf(dovf[K]),
    .o_valid(out_valid), .o_hit(hit), .o_end_x(end_x), .o_end_y(end_y)
  );

endmodule
